>>> src/rttrk_pkg.sv
// Shared types, constants and register indexes for the rate tracker.
`default_nettype none

package rttrk_pkg;

  // Defaults and fixed constants
  localparam int WindowLenDef = 8;
  localparam int WarmupMs     = 2000;
  localparam int QDepth       = 2;
  localparam int QPtrW        = 1;
  localparam int QCntW        = 2;

  localparam int InDataW  = 72;
  localparam int OutDataW = 80;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgScoreThr   = 3'd0,
    CfgRateLow    = 3'd1,
    CfgRateHigh   = 3'd2,
    CfgHitsNeeded = 3'd3,
    CfgMaxGap     = 3'd4,
    CfgContFrac   = 3'd5,
    CfgRelUpdates = 3'd6,
    CfgFreezeTail = 3'd7
  } cfg_idx_e;

  // Configuration register file
  typedef struct packed {
    logic signed [15:0] score_thr;
    logic [15:0]        rate_low;
    logic [15:0]        rate_high;
    logic [6:0]         hits_needed;
    logic [7:0]         max_gap;
    logic [15:0]        rate_tol;
    logic [15:0]        rel_updates;
    logic [15:0]        freeze_tail;
  } cfg_t;

  // Classified update handed from front end to back end
  typedef struct packed {
    logic               frozen;
    logic               above;
    logic [15:0]        rate;
    logic signed [15:0] score;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic               hit;
    logic [6:0]         hit_count;
    logic [15:0]        age_out;
    logic               latched;
    logic               frozen;
    logic [15:0]        event_count;
    logic [15:0]        rate_out;
    logic signed [15:0] score_out;
  } res_t;

endpackage

`default_nettype wire

>>> src/rttrk_front.sv
// Front end: freeze tracking and threshold/band classification of each update.
`default_nettype none

module rttrk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rttrk_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         time_ms_i,
  input  logic signed [15:0]  score_fire_i,
  input  logic [15:0]         rate_fire_i,
  input  logic                alert_on_i,
  output logic                q_push_o,
  input  logic                q_full_i,
  output rttrk_pkg::item_t    q_item_o
);

  logic [32:0] freeze_until_q, freeze_until_d;
  logic        armed_q, armed_d;
  logic        accept;
  logic        frozen;
  logic        above;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;

  // Re-arm the freeze window on output activity, then test this update against it
  always_comb begin
    freeze_until_d = freeze_until_q;
    armed_d        = armed_q;
    if (alert_on_i) begin
      freeze_until_d = {1'b0, time_ms_i} + {17'd0, cfg_i.freeze_tail};
      armed_d        = 1'b1;
    end
    frozen = armed_d && ({1'b0, time_ms_i} <= freeze_until_d);
  end

  // Score, warmup and rate band test
  assign above = (score_fire_i >= cfg_i.score_thr) &&
                 (time_ms_i >= 32'(rttrk_pkg::WarmupMs)) &&
                 (rate_fire_i >= cfg_i.rate_low) &&
                 (rate_fire_i <= cfg_i.rate_high);

  always_comb begin
    q_item_o.frozen = frozen;
    q_item_o.above  = above;
    q_item_o.rate   = rate_fire_i;
    q_item_o.score  = score_fire_i;
  end

  // Hold freeze state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freeze_until_q <= '0;
      armed_q        <= 1'b0;
    end else if (accept) begin
      freeze_until_q <= freeze_until_d;
      armed_q        <= armed_d;
    end
  end

endmodule

`default_nettype wire

>>> src/rttrk_queue.sv
// Short queue of classified updates between front end and back end.
`default_nettype none

module rttrk_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rttrk_pkg::item_t push_item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output rttrk_pkg::item_t pop_item_o
);

  rttrk_pkg::item_t                   mem_q [rttrk_pkg::QDepth];
  logic [rttrk_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [rttrk_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [rttrk_pkg::QCntW-1:0]        count_q, count_d;
  logic                               do_pop;

  assign full_o     = (count_q == rttrk_pkg::QCntW'(rttrk_pkg::QDepth));
  assign valid_o    = (count_q != '0);
  assign do_pop     = pop_i & valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == rttrk_pkg::QPtrW'(rttrk_pkg::QDepth - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rttrk_pkg::QPtrW'(rttrk_pkg::QDepth - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/rttrk_back.sv
// Back end: rate track, hit window ring, event latch and result register.
`default_nettype none

module rttrk_back #(
  parameter int WINDOW_LEN = rttrk_pkg::WindowLenDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rttrk_pkg::cfg_t  cfg_i,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  rttrk_pkg::item_t q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rttrk_pkg::res_t  out_res_o
);

  localparam int PosW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int HeldW = $clog2(WINDOW_LEN + 1);

  logic [WINDOW_LEN-1:0] ring_q, ring_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [HeldW-1:0]      held_q, held_d;
  logic                  tvalid_q, tvalid_d;
  logic [15:0]           trate_q, trate_d;
  logic [15:0]           age_q, age_d;
  logic [7:0]            miss_q, miss_d;
  logic                  latched_q, latched_d;
  logic [15:0]           quiet_q, quiet_d;
  logic [15:0]           events_q, events_d;
  logic                  out_valid_q;
  rttrk_pkg::res_t       res_q, res_d;

  logic [31:0] allow;
  logic [15:0] diff;
  logic        hit;
  logic [8:0]  gap;
  logic        pop;

  // Take the next update when the result register is free or being drained
  assign pop         = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Continuity bound and rate jump against the current track
  assign allow = 32'(cfg_i.rate_tol) * 32'(trate_q);
  assign diff  = (q_item_i.rate > trate_q) ? (q_item_i.rate - trate_q) :
                 (trate_q - q_item_i.rate);

  // Apply one update to the track, ring and latch
  always_comb begin
    ring_d    = ring_q;
    pos_d     = pos_q;
    held_d    = held_q;
    tvalid_d  = tvalid_q;
    trate_d   = trate_q;
    age_d     = age_q;
    miss_d    = miss_q;
    latched_d = latched_q;
    quiet_d   = quiet_q;
    events_d  = events_q;
    hit       = 1'b0;
    gap       = '0;
    if (!q_item_i.frozen) begin
      // Start, continue or restart the track
      if (q_item_i.above) begin
        if (tvalid_q && ({diff, 16'd0} > allow)) begin
          ring_d  = '0;
          pos_d   = '0;
          held_d  = '0;
          age_d   = '0;
          miss_d  = '0;
        end
        tvalid_d = 1'b1;
        trate_d  = q_item_i.rate;
        hit      = 1'b1;
      end
      // Push hit or miss into the window ring
      if (tvalid_d) begin
        held_d        = held_d + HeldW'(hit) - HeldW'(ring_d[pos_d]);
        ring_d[pos_d] = hit;
        pos_d         = (pos_d == PosW'(WINDOW_LEN - 1)) ? '0 : pos_d + 1'b1;
        if (age_d != 16'hFFFF) begin
          age_d = age_d + 16'd1;
        end
        if (hit) begin
          miss_d = '0;
        end else begin
          gap = {1'b0, miss_d} + 9'd1;
          if (gap > {1'b0, cfg_i.max_gap}) begin
            ring_d   = '0;
            pos_d    = '0;
            held_d   = '0;
            tvalid_d = 1'b0;
            trate_d  = '0;
            age_d    = '0;
            miss_d   = '0;
          end else begin
            miss_d = gap[7:0];
          end
        end
      end
      // Latch on enough hits, release after a quiet run
      if (!latched_q) begin
        if (tvalid_d && (7'(held_d) >= cfg_i.hits_needed)) begin
          latched_d = 1'b1;
          quiet_d   = '0;
        end
      end else begin
        if (q_item_i.above) begin
          quiet_d = '0;
        end else if (quiet_q != 16'hFFFF) begin
          quiet_d = quiet_q + 16'd1;
        end
        if (quiet_d >= cfg_i.rel_updates) begin
          if (events_q != 16'hFFFF) begin
            events_d = events_q + 16'd1;
          end
          latched_d = 1'b0;
          quiet_d   = '0;
        end
      end
    end
    res_d.hit         = hit;
    res_d.hit_count   = 7'(held_d);
    res_d.age_out     = age_d;
    res_d.latched     = latched_d;
    res_d.frozen      = q_item_i.frozen;
    res_d.event_count = events_d;
    res_d.rate_out    = q_item_i.rate;
    res_d.score_out   = q_item_i.score;
  end

  // Tracker state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q      <= '0;
      pos_q       <= '0;
      held_q      <= '0;
      tvalid_q    <= 1'b0;
      trate_q     <= '0;
      age_q       <= '0;
      miss_q      <= '0;
      latched_q   <= 1'b0;
      quiet_q     <= '0;
      events_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        ring_q    <= ring_d;
        pos_q     <= pos_d;
        held_q    <= held_d;
        tvalid_q  <= tvalid_d;
        trate_q   <= trate_d;
        age_q     <= age_d;
        miss_q    <= miss_d;
        latched_q <= latched_d;
        quiet_q   <= quiet_d;
        events_q  <= events_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> src/rate_track_m_of_n_latch.sv
// Rate-tracking M-of-N event latch with output freeze: top level.
//
// Takes one scored update per clock cycle while the queue has room and returns
// one result per update, in order, through a queue entry and then the result
// register. The front end tracks the freeze window and classifies each update,
// a two-entry queue decouples it from the back end, and the back end applies
// the update to the rate track, the hit window ring and the event latch
// combinationally (one 16x16 multiply for the continuity bound), which sustains
// one transaction per cycle when the output is not stalled. A result register
// on the output lets new updates enter while a result waits. Configuration
// writes are accepted in every cycle and must only be issued while no update
// is in flight.
`default_nettype none

module rate_track_m_of_n_latch #(
  parameter int WINDOW_LEN = rttrk_pkg::WindowLenDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: time_ms[31:0], score_fire[47:32], rate_fire[63:48],
  //        alert_on[64], zero[71:65]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rttrk_pkg::InDataW-1:0]     s_axis_tdata,
  // tdata: hit[0], hit_count[7:1], age_out[23:8], latched[24], frozen[25],
  //        event_count[41:26], rate_out[57:42], score_out[73:58], zero[79:74]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rttrk_pkg::OutDataW-1:0]    m_axis_tdata,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rttrk_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [rttrk_pkg::CfgDataW-1:0]    cfg_data_i
);

  rttrk_pkg::cfg_t  cfg_q, cfg_d;
  rttrk_pkg::item_t push_item, pop_item;
  rttrk_pkg::res_t  res;
  logic             q_push, q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rttrk_pkg::cfg_idx_e'(cfg_addr_i))
        rttrk_pkg::CfgScoreThr:   cfg_d.score_thr   = $signed(cfg_data_i);
        rttrk_pkg::CfgRateLow:    cfg_d.rate_low    = cfg_data_i;
        rttrk_pkg::CfgRateHigh:   cfg_d.rate_high   = cfg_data_i;
        rttrk_pkg::CfgHitsNeeded: cfg_d.hits_needed = cfg_data_i[6:0];
        rttrk_pkg::CfgMaxGap:     cfg_d.max_gap     = cfg_data_i[7:0];
        rttrk_pkg::CfgContFrac:   cfg_d.rate_tol    = cfg_data_i;
        rttrk_pkg::CfgRelUpdates: cfg_d.rel_updates = cfg_data_i;
        rttrk_pkg::CfgFreezeTail: cfg_d.freeze_tail = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_thr   <= 16'sd1536;
      cfg_q.rate_low    <= 16'd0;
      cfg_q.rate_high   <= 16'hFFFF;
      cfg_q.hits_needed <= 7'd6;
      cfg_q.max_gap     <= 8'd2;
      cfg_q.rate_tol    <= 16'd6554;
      cfg_q.rel_updates <= 16'd8;
      cfg_q.freeze_tail <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rttrk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .time_ms_i       (s_axis_tdata[31:0]),
    .score_fire_i    ($signed(s_axis_tdata[47:32])),
    .rate_fire_i     (s_axis_tdata[63:48]),
    .alert_on_i      (s_axis_tdata[64]),
    .q_push_o        (q_push),
    .q_full_i        (q_full),
    .q_item_o        (push_item)
  );

  rttrk_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item)
  );

  rttrk_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (pop_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {6'd0, res.score_out, res.rate_out, res.event_count,
                         res.frozen, res.latched, res.age_out, res.hit_count,
                         res.hit};

endmodule

`default_nettype wire

>>> src/rttrk_checker.sv
// Port-level checks on the rate tracker and their binding to the top level.
`default_nettype none

module rttrk_checker #(
  parameter int WINDOW_LEN = rttrk_pkg::WindowLenDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rttrk_pkg::OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A frozen update never counts as a hit
  a_frozen_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> !m_axis_tdata[0])
    else $error("hit reported on a frozen update");

  // A hit sits in the ring, so the ring count cannot be zero
  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:1] != 7'd0)
    else $error("hit without any hit in the window");

  // Ring count never exceeds the window length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] <= 7'(WINDOW_LEN))
    else $error("hit count above window length");

endmodule

bind rate_track_m_of_n_latch rttrk_checker #(
  .WINDOW_LEN (WINDOW_LEN)
) u_rttrk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
